// ===== rtl/ssh_pkg.sv =====
// Shared types, rule codes and constants of the selectable string hash.
`timescale 1ns / 1ps
`default_nettype none

package ssh_pkg;

	typedef logic [2:0]  alg_t;
	typedef logic [63:0] word64_t;

	localparam alg_t ALG_SDBM = 3'd0;
	localparam alg_t ALG_RS   = 3'd1;
	localparam alg_t ALG_JS   = 3'd2;
	localparam alg_t ALG_PJW  = 3'd3;
	localparam alg_t ALG_ELF  = 3'd4;
	localparam alg_t ALG_BKDR = 3'd5;
	localparam alg_t ALG_DJB  = 3'd6;
	localparam alg_t ALG_AP   = 3'd7;

	localparam logic REG_ALGORITHM = 1'b0;
	localparam logic REG_BKDR_SEED = 1'b1;

	localparam word64_t RS_START_MUL = 64'd63689;
	localparam word64_t RS_STEP_MUL  = 64'd378551;
	localparam word64_t JS_START     = 64'd1315423911;
	localparam word64_t DJB_START    = 64'd5381;
	localparam word64_t ELF_TOP      = 64'h00000000_F0000000;
	localparam word64_t PJW_ONES     = 64'h00000000_FFFFFFFF;
	localparam logic [31:0] BKDR_SEED_RESET = 32'd131;

	// start value of each rule, before masking to the word width
	function automatic word64_t start_value(alg_t alg);
		word64_t v;
		v = '0;
		if (alg == ALG_JS)
			v = JS_START;
		else if (alg == ALG_DJB)
			v = DJB_START;
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ssh_mul.sv =====
// 64-bit wrapping product built from three 32x32 partial products.
`timescale 1ns / 1ps
`default_nettype none

module ssh_mul (
	input  wire ssh_pkg::word64_t a,
	input  wire ssh_pkg::word64_t b,
	output ssh_pkg::word64_t      p
);
	import ssh_pkg::*;

	logic [63:0] lo_lo;
	logic [31:0] lo_hi;
	logic [31:0] hi_lo;
	logic [31:0] mid_sum;

	assign lo_lo   = a[31:0] * b[31:0];
	assign lo_hi   = a[31:0] * b[63:32];
	assign hi_lo   = a[63:32] * b[31:0];
	assign mid_sum = lo_hi + hi_lo;
	assign p       = lo_lo + {mid_sum, 32'b0};

endmodule

`default_nettype wire

// ===== rtl/ssh_fold.sv =====
// One byte step of the selected hash rule, plus the RS multiplier update.
`timescale 1ns / 1ps
`default_nettype none

module ssh_fold #(
	parameter int WORD_BITS = 64
) (
	input  wire ssh_pkg::alg_t         alg,
	input  wire                        odd,
	input  wire  [WORD_BITS-1:0]       hash,
	input  wire  [WORD_BITS-1:0]       rs_mul,
	input  wire  [31:0]                seed,
	input  wire  [7:0]                 text_byte,
	output logic [WORD_BITS-1:0]       hash_next,
	output logic [WORD_BITS-1:0]       rs_mul_next
);
	import ssh_pkg::*;

	localparam word64_t WORD_MASK = {64{1'b1}} >> (64 - WORD_BITS);
	localparam int      PJW_UP    = WORD_BITS / 8;
	localparam int      PJW_DOWN  = (WORD_BITS * 3) / 4;
	localparam word64_t PJW_HIGH  = (PJW_ONES << (WORD_BITS - WORD_BITS / 8)) & WORD_MASK;

	word64_t h;
	word64_t c;
	word64_t m_opnd;
	word64_t prod;
	word64_t rs_prod;
	word64_t t;
	word64_t r;

	assign h = 64'(hash);
	assign c = {{56{text_byte[7]}}, text_byte};
	// RS and BKDR share one product unit
	assign m_opnd = (alg == ALG_RS) ? 64'(rs_mul) : {32'b0, seed};

	ssh_mul u_hash_mul (
		.a (h),
		.b (m_opnd),
		.p (prod)
	);

	ssh_mul u_rs_mul (
		.a (64'(rs_mul)),
		.b (RS_STEP_MUL),
		.p (rs_prod)
	);

	always_comb begin
		t = '0;
		r = h;
		unique case (alg)
			ALG_SDBM: r = c + (h << 6) + (h << 16) - h;
			ALG_RS, ALG_BKDR: r = prod + c;
			ALG_JS:   r = h ^ ((h << 5) + c + (h >> 2));
			ALG_PJW: begin
				r = ((h << PJW_UP) + c) & WORD_MASK;
				t = r & PJW_HIGH;
				if (t != '0)
					r = (r ^ (t >> PJW_DOWN)) & ~PJW_HIGH;
			end
			ALG_ELF: begin
				r = ((h << 4) + c) & WORD_MASK;
				t = r & ELF_TOP;
				if (t != '0)
					r = (r ^ (t >> 24)) & ~t;
			end
			ALG_DJB:  r = h + (h << 5) + c;
			ALG_AP: begin
				if (!odd)
					r = h ^ ((h << 7) ^ c ^ (h >> 3));
				else
					r = h ^ ~((h << 11) ^ c ^ (h >> 5));
			end
			default:  r = h;
		endcase
	end

	assign hash_next   = r[WORD_BITS-1:0];
	assign rs_mul_next = rs_prod[WORD_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/selectable_string_hash.sv =====
// Selectable string hash: byte stream in, 31-bit hash out per string.
//
// Input channel: text_byte/last_byte with byte_valid/byte_ready. Each
// transaction carries one byte of a string; last_byte marks its final byte.
// Output channel: hash_value with hash_valid/hash_ready, one transaction per
// string, holding the final hash masked to 31 bits.
// Config port: cfg_we/cfg_index/cfg_data, index 0 selects the rule
// (0 sdbm .. 7 ap) and restarts the string, index 1 sets the BKDR seed.
// Write it only while no string is in flight.
// Throughput is one byte per cycle while byte_ready is high. A byte waits
// in the input register, then the hash loop (three 32x32 partial products
// and an add) folds it in; hash_valid rises as the last byte of a string
// leaves the input register. If hash_ready stays low, the output register
// holds the result, bytes keep flowing until the next last byte reaches the
// input register, and byte_ready then drops until the result is taken.
// Reset selects SDBM with seed 131 and clears both channels.
`timescale 1ns / 1ps
`default_nettype none

module selectable_string_hash #(
	parameter int WORD_BITS = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [31:0] cfg_data,
	input  wire  [7:0]  text_byte,
	input  wire         last_byte,
	input  wire         byte_valid,
	output logic        byte_ready,
	output logic [30:0] hash_value,
	output logic        hash_valid,
	input  wire         hash_ready
);
	import ssh_pkg::*;

	localparam word64_t SDBM_START = start_value(ALG_SDBM);

	alg_t                 alg_q;
	logic [31:0]          seed_q;
	logic [WORD_BITS-1:0] hash_q;
	logic [WORD_BITS-1:0] rs_mul_q;
	logic                 odd_q;
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	logic                 advance;
	logic [WORD_BITS-1:0] hash_next;
	logic [WORD_BITS-1:0] rs_mul_next;
	word64_t              cfg_start;
	word64_t              cur_start;

	// only a last byte needs room in the output register
	assign advance    = valid_s1 && (!last_s1 || !hash_valid || hash_ready);
	assign byte_ready = !valid_s1 || advance;
	assign cfg_start  = start_value(cfg_data[2:0]);
	assign cur_start  = start_value(alg_q);

	ssh_fold #(
		.WORD_BITS (WORD_BITS)
	) u_fold (
		.alg         (alg_q),
		.odd         (odd_q),
		.hash        (hash_q),
		.rs_mul      (rs_mul_q),
		.seed        (seed_q),
		.text_byte   (byte_s1),
		.hash_next   (hash_next),
		.rs_mul_next (rs_mul_next)
	);

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
		if (advance && last_s1)
			hash_value <= hash_next[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q      <= ALG_SDBM;
			seed_q     <= BKDR_SEED_RESET;
			hash_q     <= SDBM_START[WORD_BITS-1:0];
			rs_mul_q   <= RS_START_MUL[WORD_BITS-1:0];
			odd_q      <= 1'b0;
			valid_s1   <= 1'b0;
			hash_valid <= 1'b0;
		end else begin
			if (byte_valid && byte_ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;

			if (advance && last_s1)
				hash_valid <= 1'b1;
			else if (hash_ready)
				hash_valid <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_ALGORITHM: begin
						alg_q    <= cfg_data[2:0];
						hash_q   <= cfg_start[WORD_BITS-1:0];
						rs_mul_q <= RS_START_MUL[WORD_BITS-1:0];
						odd_q    <= 1'b0;
					end
					REG_BKDR_SEED: seed_q <= cfg_data;
					default: ;
				endcase
			end else if (advance) begin
				if (last_s1) begin
					hash_q   <= cur_start[WORD_BITS-1:0];
					rs_mul_q <= RS_START_MUL[WORD_BITS-1:0];
					odd_q    <= 1'b0;
				end else begin
					hash_q <= hash_next;
					if (alg_q == ALG_RS)
						rs_mul_q <= rs_mul_next;
					odd_q <= ~odd_q;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the selectable string hash block.
`timescale 1ns / 1ps

module testbench;
	import ssh_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 6;
	localparam bit [63:0] PJW_HIGH = PJW_ONES << 56;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic [7:0]  text_byte;
	logic        last_byte;
	logic        byte_valid;
	logic        byte_ready;
	logic [30:0] hash_value;
	logic        hash_valid;
	logic        hash_ready;

	// shadow copy of the block state
	alg_t        model_alg;
	bit [31:0]   model_seed;
	bit [63:0]   model_hash;
	bit [63:0]   model_rs_mul;
	bit          model_odd;

	bit [30:0]   expected_hashes[$];
	bit [30:0]   oldest_hash;
	int          error_count = 0;
	int          cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_off_left = 0;

	selectable_string_hash i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.text_byte (text_byte),
		.last_byte (last_byte),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.hash_value(hash_value),
		.hash_valid(hash_valid),
		.hash_ready(hash_ready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit [63:0] rule_start(alg_t alg);
		case (alg)
			ALG_JS:  return JS_START;
			ALG_DJB: return DJB_START;
			default: return 64'd0;
		endcase
	endfunction

	task automatic restart_string();
		model_hash = rule_start(model_alg);
		model_rs_mul = RS_START_MUL;
		model_odd = 1'b0;
	endtask

	function automatic bit [63:0] fold_byte(bit [63:0] h, bit [7:0] b);
		bit [63:0] c;
		bit [63:0] t;
		c = {{56{b[7]}}, b};
		case (model_alg)
			ALG_SDBM: h = c + (h << 6) + (h << 16) - h;
			ALG_RS:   h = h * model_rs_mul + c;
			ALG_JS:   h = h ^ ((h << 5) + c + (h >> 2));
			ALG_PJW: begin
				h = (h << 8) + c;
				t = h & PJW_HIGH;
				if (t != 0)
					h = (h ^ (t >> 48)) & ~PJW_HIGH;
			end
			ALG_ELF: begin
				h = (h << 4) + c;
				t = h & ELF_TOP;
				if (t != 0) begin
					h = h ^ (t >> 24);
					h = h & ~t;
				end
			end
			ALG_BKDR: h = h * {32'd0, model_seed} + c;
			ALG_DJB:  h = h + (h << 5) + c;
			default: begin
				if (!model_odd)
					h = h ^ ((h << 7) ^ c ^ (h >> 3));
				else
					h = h ^ ~((h << 11) ^ c ^ (h >> 5));
			end
		endcase
		return h;
	endfunction

	task automatic predict_byte(input bit [7:0] b, input bit last);
		model_hash = fold_byte(model_hash, b);
		if (model_alg == ALG_RS)
			model_rs_mul = model_rs_mul * RS_STEP_MUL;
		model_odd = ~model_odd;
		if (last) begin
			expected_hashes.push_back(model_hash[30:0]);
			restart_string();
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// leaves valid high so back-to-back bytes need no second assignment
	task automatic send_byte(input bit [7:0] b, input bit last);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_valid = 1'b0;
			@(negedge clk);
		end
		text_byte = b;
		last_byte = last;
		byte_valid = 1'b1;
		do @(posedge clk); while (!byte_ready);
		predict_byte(b, last);
	endtask

	function automatic bit [7:0] pick_byte();
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0:       return 8'h00;
				1:       return 8'h7F;
				2:       return 8'h80;
				default: return 8'hFF;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_string(input int len);
		for (int i = 0; i < len; i++)
			send_byte(pick_byte(), i == len - 1);
	endtask

	task automatic wait_results_done();
		@(negedge clk);
		byte_valid = 1'b0;
		while (expected_hashes.size() != 0)
			@(posedge clk);
	endtask

	// bytes without a last flag may still be in the pipe after the queue empties
	task automatic wait_idle();
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic idx, input bit [31:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		if (idx == REG_ALGORITHM) begin
			model_alg = data[2:0];
			restart_string();
		end else begin
			model_seed = data;
		end
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic select_rule(input alg_t alg);
		write_config(REG_ALGORITHM, {29'($urandom_range(0, 32'h1FFFFFFF)), alg});
	endtask

	task automatic set_idling(input int send_pct, input int stall_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	// receiver side, with an optional long hold-off counted here
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			hash_ready = 1'b0;
			hold_off_left--;
		end else begin
			hash_ready = ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && hash_valid && hash_ready) begin
			if (expected_hashes.size() == 0) begin
				report_mismatch($sformatf("hash %h with no string pending", hash_value));
			end else begin
				oldest_hash = expected_hashes.pop_front();
				if (hash_value !== oldest_hash)
					report_mismatch($sformatf("hash_value %h, predicted %h",
						hash_value, oldest_hash));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// reset defaults, zero bytes, sign extension, then every rule once
	task automatic test_rules();
		set_idling(0, 0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'h00, 1'b1);
		for (int a = 0; a < 8; a++) begin
			wait_idle();
			select_rule(alg_t'(a));
			send_byte(8'h80, 1'b0);
			send_byte(8'hFF, 1'b1);
		end
		wait_idle();
	endtask

	// rule change drops the open string; seed change keeps it
	task automatic test_config_mid_string();
		select_rule(ALG_RS);
		send_byte(8'h41, 1'b0);
		send_byte(8'hC3, 1'b0);
		wait_idle();
		select_rule(ALG_DJB);
		send_byte(8'h5A, 1'b1);
		wait_idle();
		select_rule(ALG_BKDR);
		send_byte(8'h9E, 1'b0);
		wait_idle();
		write_config(REG_BKDR_SEED, 32'hFFFFFFFF);
		send_byte(8'h33, 1'b0);
		wait_idle();
		write_config(REG_BKDR_SEED, 32'h00000000);
		send_byte(8'hE7, 1'b1);
		wait_idle();
	endtask

	task automatic test_random_strings(input int send_pct, input int stall_pct,
			input int first_rule, input int item_goal);
		int sent;
		int len;
		bit [31:0] seed;
		set_idling(send_pct, stall_pct);
		for (int part = 0; part < 4; part++) begin
			wait_idle();
			select_rule(alg_t'((first_rule + part) % 8));
			if ($urandom_range(0, 1) == 1) begin
				case ($urandom_range(0, 3))
					0:       seed = 32'h00000000;
					1:       seed = 32'hFFFFFFFF;
					default: seed = $urandom;
				endcase
				write_config(REG_BKDR_SEED, seed);
			end
			sent = 0;
			while (sent < item_goal / 4) begin
				// long strings reach the overflow folds of pjw and elf
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40)
					: $urandom_range(1, 10);
				send_string(len);
				sent += len;
			end
		end
		wait_idle();
	endtask

	// result held back long enough for the block to stall its input
	task automatic test_backpressure();
		set_idling(0, 0);
		select_rule(ALG_AP);
		@(posedge clk);
		hold_off_left = 300;
		for (int i = 0; i < 15; i++)
			send_string($urandom_range(1, 3));
		wait_results_done();
		for (int i = 0; i < 8; i++)
			send_string($urandom_range(1, 4));
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ALGORITHM;
		cfg_data = '0;
		text_byte = '0;
		last_byte = 1'b0;
		byte_valid = 1'b0;
		hash_ready = 1'b0;
		model_alg = ALG_SDBM;
		model_seed = BKDR_SEED_RESET;
		restart_string();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_rules();
		test_config_mid_string();
		test_random_strings(0, 0, 0, 160);
		test_random_strings(69, 0, 4, 160);
		test_random_strings(0, 69, 2, 160);
		test_random_strings(36, 36, 6, 160);
		test_backpressure();

		wait_results_done();
		repeat (10) @(posedge clk);
		if (expected_hashes.size() != 0)
			report_mismatch($sformatf("%0d hashes never arrived", expected_hashes.size()));
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
